/* hdl/base64url_codec_macros.svh */
// assertion helpers for the codec modules, used by b64url_back
// both expect clk_i and rst_ni in the scope where they are used
`ifndef BASE64URL_CODEC_MACROS_SVH
`define BASE64URL_CODEC_MACROS_SVH

// condition must hold in the same cycle
`define B64URL_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("b64url check failed");

// condition must hold in the next cycle
`define B64URL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("b64url check failed");

`endif

/* hdl/b64url_pkg.sv */
`timescale 1ns / 1ps

package b64url_pkg;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_DIRECTION = 1'b0;

  // direction register values
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_PAD      = 2'd2;

  // alphabet anchors
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DASH    = 8'h2d;
  localparam logic [7:0] CHAR_UNDER   = 8'h5f;

  // one result word
  typedef struct packed {
    logic [7:0] value;
    logic       has_data;
    logic       stream_end;
    logic [1:0] status;
  } b64url_res_t;

  // all result words caused by one input word
  typedef struct packed {
    logic [1:0]  count;
    b64url_res_t r1;
    b64url_res_t r0;
  } b64url_entry_t;

  // register write toward the front
  typedef struct packed {
    logic wr_en;
    logic direction;
  } b64url_cfg_t;

  // 6-bit group to alphabet character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'(v) + CHAR_UPPER_A;
    end else if (v < 6'd52) begin
      c = 8'(v) - 8'd26 + CHAR_LOWER_A;
    end else if (v < 6'd62) begin
      c = 8'(v) - 8'd52 + CHAR_ZERO;
    end else if (v == 6'd62) begin
      c = CHAR_DASH;
    end else begin
      c = CHAR_UNDER;
    end
    return c;
  endfunction

  // character to 6-bit group, bit 6 set for a character outside the alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] v;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      v = 7'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      v = 7'(c - CHAR_LOWER_A + 8'd26);
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = 7'(c - CHAR_ZERO + 8'd52);
    end else if (c == CHAR_DASH) begin
      v = 7'd62;
    end else if (c == CHAR_UNDER) begin
      v = 7'd63;
    end else begin
      v = 7'd64;
    end
    return v;
  endfunction

endpackage

/* hdl/b64url_front.sv */
`timescale 1ns / 1ps

module b64url_front import b64url_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b64url_cfg_t   cfg_i,
  input  logic          accept_i,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  output b64url_entry_t entry_o,
  output logic          entry_valid_o,
  output logic          direction_o
);

  logic        dir_q;
  logic [11:0] buf_q, buf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        skip_q, skip_d;

  logic [11:0] enc_buf, dec_buf;
  logic [3:0]  enc_cnt, enc_rem, dec_cnt, dec_rem;
  logic [6:0]  sext;
  logic        dec_left;
  b64url_entry_t entry;

  // classify the word and build its result words
  always_comb begin
    entry    = '0;
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    skip_d   = skip_q;
    enc_buf  = {buf_q[3:0], data_i};
    enc_cnt  = cnt_q + 4'd8;
    enc_rem  = enc_cnt - 4'd6;
    sext     = char_to_sextet(data_i);
    dec_buf  = {buf_q[5:0], sext[5:0]};
    dec_cnt  = cnt_q + 4'd6;
    dec_rem  = (dec_cnt >= 4'd8) ? dec_cnt - 4'd8 : dec_cnt;
    dec_left = (dec_buf & ~(12'hfff << dec_rem)) != 12'd0;

    if (dir_q == DIR_ENCODE) begin
      // one or two characters, plus a zero-filled one at the end if bits are left over
      entry.count       = 2'd1;
      entry.r0.value    = sextet_to_char(6'(enc_buf >> enc_rem));
      entry.r0.has_data = 1'b1;
      buf_d             = enc_buf;
      if (enc_cnt == 4'd12) begin
        entry.count       = 2'd2;
        entry.r1.value    = sextet_to_char(enc_buf[5:0]);
        entry.r1.has_data = 1'b1;
        cnt_d             = 4'd0;
      end else begin
        cnt_d = enc_rem;
        if (last_i) begin
          entry.count       = 2'd2;
          entry.r1.value    = sextet_to_char(6'(enc_buf[5:0] << (4'd6 - enc_rem)));
          entry.r1.has_data = 1'b1;
        end
      end
      if (last_i) begin
        if (entry.count == 2'd2) begin
          entry.r1.stream_end = 1'b1;
        end else begin
          entry.r0.stream_end = 1'b1;
        end
        buf_d  = '0;
        cnt_d  = '0;
        skip_d = 1'b0;
      end
    end else if (skip_q) begin
      // dropping words after a bad character
      if (last_i) begin
        entry.count         = 2'd1;
        entry.r0.stream_end = 1'b1;
        entry.r0.status     = ST_BAD_CHAR;
        buf_d               = '0;
        cnt_d               = '0;
        skip_d              = 1'b0;
      end
    end else if (sext[6]) begin
      // character outside the alphabet
      entry.count         = 2'd1;
      entry.r0.stream_end = last_i;
      entry.r0.status     = ST_BAD_CHAR;
      buf_d               = '0;
      cnt_d               = '0;
      skip_d              = !last_i;
    end else begin
      buf_d = dec_buf;
      cnt_d = dec_rem;
      if (dec_cnt >= 4'd8) begin
        entry.count       = 2'd1;
        entry.r0.value    = 8'(dec_buf >> dec_rem);
        entry.r0.has_data = 1'b1;
      end
      // end of stream carries the padding check
      if (last_i) begin
        entry.count         = 2'd1;
        entry.r0.stream_end = 1'b1;
        entry.r0.status     = dec_left ? ST_PAD : ST_OK;
        buf_d               = '0;
        cnt_d               = '0;
        skip_d              = 1'b0;
      end
    end
  end

  // stream state and direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= DIR_ENCODE;
      buf_q  <= '0;
      cnt_q  <= '0;
      skip_q <= 1'b0;
    end else if (cfg_i.wr_en) begin
      dir_q  <= cfg_i.direction;
      buf_q  <= '0;
      cnt_q  <= '0;
      skip_q <= 1'b0;
    end else if (accept_i) begin
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
    end
  end

  assign entry_o       = entry;
  assign entry_valid_o = accept_i && (entry.count != 2'd0);
  assign direction_o   = dir_q;

endmodule

/* hdl/b64url_fifo.sv */
`timescale 1ns / 1ps

module b64url_fifo import b64url_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  b64url_entry_t wr_entry_i,
  input  logic          rd_en_i,
  output b64url_entry_t rd_entry_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64url_entry_t   slots_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slots_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en_i && !wr_en_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign rd_entry_o = slots_q[rd_ptr_q];
  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == FULL_CNT);

endmodule

/* hdl/b64url_back.sv */
`timescale 1ns / 1ps
`include "base64url_codec_macros.svh"

module b64url_back import b64url_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b64url_entry_t head_i,
  input  logic          head_empty_i,
  output logic          deq_o,
  input  logic          pop_i,
  output b64url_res_t   res_o,
  output logic          empty_o
);

  b64url_res_t out_q;
  logic        valid_q;
  logic        idx_q;
  logic        load;
  logic        entry_done;

  // move the next result word into the output register
  assign load       = !head_empty_i && (!valid_q || pop_i);
  assign entry_done = idx_q || (head_i.count == 2'd1);
  assign deq_o      = load && entry_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= !entry_done;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // output word, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= idx_q ? head_i.r1 : head_i.r0;
    end
  end

  assign res_o   = out_q;
  assign empty_o = !valid_q;

  // second word pending only for a queued two-word entry
  `B64URL_ASSERT_NOW(a_idx_two_words, idx_q, !head_empty_i && head_i.count == 2'd2)
  // queued entries always carry a word
  `B64URL_ASSERT_NOW(a_head_nonzero, !head_empty_i, head_i.count != 2'd0)
  // finishing an entry restarts at its first word
  `B64URL_ASSERT_NEXT(a_deq_resets_idx, deq_o, !idx_q)

endmodule

/* hdl/base64url_codec.sv */
`timescale 1ns / 1ps

// Streaming URL-safe base64 (A-Z, a-z, 0-9, '-', '_') encoder and decoder without
// padding. Register 0 (direction) selects encode (0) or decode (1); writing it starts
// a new stream. Each input word yields zero, one or two result words: encoding gives
// one or two characters per byte plus, on the last byte, a zero-filled character
// when bits are left over, decoding gives a byte per full 8 bits, status 1 for a bad
// character (the rest of the stream up to its last word is dropped, then one status
// word closes it) and status 2 for nonzero leftover bits at the end. A new input
// word is taken every cycle while the entry queue has room; the result port
// delivers one word per cycle while pop is held and a result is queued, and
// decoding runs at one character per cycle while results are popped. Results pass
// through the entry queue and then the output register to the result port.
module base64url_codec import b64url_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input queue side
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_value_i,
  input  logic              is_last_i,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_value_o,
  output logic              has_data_o,
  output logic              stream_end_o,
  output logic [1:0]        status_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  b64url_cfg_t   cfg;
  b64url_entry_t entry, head;
  b64url_res_t   res;
  logic          accept;
  logic          entry_valid;
  logic          head_empty;
  logic          deq;
  logic          q_full;
  logic          direction;
  logic          reg_hit;

  // register access
  assign pready        = 1'b1;
  assign reg_hit       = (paddr[2] == REG_DIRECTION);
  assign cfg.wr_en     = psel && penable && pwrite && pready && reg_hit;
  assign cfg.direction = pwdata[0];
  assign prdata        = reg_hit ? {{(APB_DW - 1){1'b0}}, direction} : '0;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64url_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .data_i        (data_value_i),
    .last_i        (is_last_i),
    .entry_o       (entry),
    .entry_valid_o (entry_valid),
    .direction_o   (direction)
  );

  b64url_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (entry_valid),
    .wr_entry_i (entry),
    .rd_en_i    (deq),
    .rd_entry_o (head),
    .empty_o    (head_empty),
    .full_o     (q_full)
  );

  b64url_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .deq_o        (deq),
    .pop_i        (pop),
    .res_o        (res),
    .empty_o      (empty)
  );

  assign out_value_o  = res.value;
  assign has_data_o   = res.has_data;
  assign stream_end_o = res.stream_end;
  assign status_o     = res.status;

endmodule

/* tb/base64url_codec_tb.sv */
`timescale 1ns / 1ps

module base64url_codec_tb;
  import b64url_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_WORDS   = 38;
  localparam logic [APB_AW-1:0] DIR_ADDR = APB_AW'(4 * int'(REG_DIRECTION));

  // codec model plus the queue of result words still owed by the block
  class codec_tracker;
    logic        direction;
    logic [11:0] bit_buf;
    logic [3:0]  bit_cnt;
    logic        skipping;
    b64url_res_t expected_words[$];
    int unsigned mismatches;

    function new();
      direction = DIR_ENCODE;
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      bit_buf = '0;
      bit_cnt = '0;
      skipping = 1'b0;
    endfunction

    // a register write always starts a fresh stream
    function void set_direction(logic d);
      direction = d;
      clear_stream();
    endfunction

    static function b64url_res_t make_word(logic [7:0] v, logic h, logic e, logic [1:0] s);
      b64url_res_t w;
      w.value = v;
      w.has_data = h;
      w.stream_end = e;
      w.status = s;
      return w;
    endfunction

    static function logic [7:0] to_char(logic [5:0] v);
      logic [7:0] c;
      if (v <= 6'd25) begin
        c = CHAR_UPPER_A + 8'(v);
      end else if (v <= 6'd51) begin
        c = CHAR_LOWER_A + 8'(v - 6'd26);
      end else if (v <= 6'd61) begin
        c = CHAR_ZERO + 8'(v - 6'd52);
      end else if (v == 6'd62) begin
        c = CHAR_DASH;
      end else begin
        c = CHAR_UNDER;
      end
      return c;
    endfunction

    // returns 0 for a character outside the alphabet
    static function bit to_sextet(input logic [7:0] c, output logic [5:0] v);
      bit ok;
      ok = 1'b1;
      v = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
        v = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
        v = 6'(c - CHAR_LOWER_A) + 6'd26;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        v = 6'(c - CHAR_ZERO) + 6'd52;
      end else if (c == CHAR_DASH) begin
        v = 6'd62;
      end else if (c == CHAR_UNDER) begin
        v = 6'd63;
      end else begin
        ok = 1'b0;
      end
      return ok;
    endfunction

    function bit drops_next();
      return direction == DIR_DECODE && skipping;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // predict the result words of one accepted input word
    function void note_word(logic [7:0] data, logic last);
      b64url_res_t caused[$];
      b64url_res_t w;
      logic [5:0]  sx;
      logic [11:0] mask;
      logic [1:0]  st;
      if (direction == DIR_ENCODE) begin
        bit_buf = {bit_buf[3:0], data};
        bit_cnt = bit_cnt + 4'd8;
        while (bit_cnt >= 4'd6) begin
          bit_cnt = bit_cnt - 4'd6;
          w = make_word(to_char(6'(bit_buf >> bit_cnt)), 1'b1, 1'b0, ST_OK);
          caused = {caused, w};
        end
        if (last) begin
          // zero-fill the leftover bits into one more character
          if (bit_cnt != 4'd0) begin
            w = make_word(to_char(6'(bit_buf << (4'd6 - bit_cnt))), 1'b1, 1'b0, ST_OK);
            caused = {caused, w};
          end
          w = caused.pop_back();
          w.stream_end = 1'b1;
          caused = {caused, w};
          clear_stream();
        end
      end else if (skipping) begin
        // dropping the rest of a broken stream
        if (last) begin
          caused = {caused, make_word(8'h00, 1'b0, 1'b1, ST_BAD_CHAR)};
          clear_stream();
        end
      end else if (!to_sextet(data, sx)) begin
        caused = {caused, make_word(8'h00, 1'b0, last, ST_BAD_CHAR)};
        clear_stream();
        skipping = !last;
      end else begin
        bit_buf = {bit_buf[5:0], sx};
        bit_cnt = bit_cnt + 4'd6;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = bit_cnt - 4'd8;
          caused = {caused, make_word(8'(bit_buf >> bit_cnt), 1'b1, 1'b0, ST_OK)};
        end
        if (last) begin
          // leftover bits must be zero
          mask = (12'd1 << bit_cnt) - 12'd1;
          st = ((bit_buf & mask) != 12'd0) ? ST_PAD : ST_OK;
          if (caused.size() != 0) begin
            w = caused.pop_back();
            w.stream_end = 1'b1;
            w.status = st;
            caused = {caused, w};
          end else begin
            caused = {caused, make_word(8'h00, 1'b0, 1'b1, st)};
          end
          clear_stream();
        end
      end
      expected_words = {expected_words, caused};
    endfunction

    function void flag(string what);
      if (mismatches < 10) $display("%s", what);
      mismatches++;
    endfunction

    // compare one popped word with the oldest prediction
    // fields shown as value/has_data/stream_end/status
    function void check_word(b64url_res_t got);
      b64url_res_t want;
      if (expected_words.size() == 0) begin
        flag($sformatf("unexpected word: value %h has_data %0b end %0b status %0d",
                       got.value, got.has_data, got.stream_end, got.status));
        return;
      end
      want = expected_words.pop_front();
      if (got.value !== want.value || got.has_data !== want.has_data ||
          got.stream_end !== want.stream_end || got.status !== want.status) begin
        flag($sformatf("word mismatch: expected %h/%0b/%0b/%0d, got %h/%0b/%0b/%0d",
                       want.value, want.has_data, want.stream_end, want.status,
                       got.value, got.has_data, got.stream_end, got.status));
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [7:0]        data_value_i;
  logic              is_last_i;
  logic              empty;
  logic              pop;
  logic [7:0]        out_value_o;
  logic              has_data_o;
  logic              stream_end_o;
  logic [1:0]        status_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  codec_tracker tracker;
  int unsigned  cycles;
  bit           hold_req;
  bit           tx_steady;
  bit           rx_steady;

  base64url_codec dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_value_i (data_value_i),
    .is_last_i    (is_last_i),
    .empty        (empty),
    .pop          (pop),
    .out_value_o  (out_value_o),
    .has_data_o   (has_data_o),
    .stream_end_o (stream_end_o),
    .status_o     (status_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check popped words, stall at random or on request
  initial begin : result_side
    int unsigned stall;
    int unsigned r;
    b64url_res_t got;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.value = out_value_o;
        got.has_data = has_data_o;
        got.stream_end = stream_end_o;
        got.status = status_o;
        tracker.check_word(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        stall--;
        pop <= 1'b0;
      end else if (rx_steady) begin
        pop <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          pop <= 1'b1;
        end else begin
          stall = (r < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
          pop <= 1'b0;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_word(input logic [7:0] d, input logic last);
    int unsigned gap;
    push <= 1'b1;
    data_value_i <= d;
    is_last_i <= last;
    do @(posedge clk_i); while (full);
    tracker.note_word(d, last);
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every owed word, then let the block go quiet
  task automatic settle();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_reg(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_direction_reg();
    logic [APB_DW-1:0] rd;
    read_reg(DIR_ADDR, rd);
    if (rd !== APB_DW'(tracker.direction)) begin
      tracker.flag($sformatf("direction readback: expected %0d, got %h",
                             tracker.direction, rd));
    end
  endtask

  task automatic set_direction(input logic d);
    settle();
    write_reg(DIR_ADDR, APB_DW'(d));
    tracker.set_direction(d);
    check_direction_reg();
  endtask

  initial begin : stimulus
    logic       dir;
    logic       last;
    logic [7:0] d;
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    push = 1'b0;
    data_value_i = '0;
    is_last_i = 1'b0;
    pop = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    tracker = new();
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_direction_reg();

    // encode: four leftover bits, no leftover with dashes, no leftover with underscores, two leftover bits
    set_direction(DIR_ENCODE);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'hfb, 1'b0);
    send_word(8'hef, 1'b0);
    send_word(8'hbe, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'h80, 1'b1);

    // decode: clean and padded ends, with and without a final byte
    set_direction(DIR_DECODE);
    send_word("Q", 1'b0);
    send_word("Q", 1'b1);
    send_word("Q", 1'b0);
    send_word("R", 1'b1);
    send_word("A", 1'b1);
    send_word("B", 1'b1);
    // bad character mid stream, then skipped words up to the last
    send_word("A", 1'b0);
    send_word("=", 1'b0);
    send_word("x", 1'b0);
    send_word("y", 1'b1);
    // bad character as the last word
    send_word("=", 1'b1);
    // alphabet edges
    send_word("-", 1'b0);
    send_word("_", 1'b0);
    send_word("z", 1'b0);
    send_word("9", 1'b1);
    send_word("0", 1'b0);
    send_word("a", 1'b0);
    send_word("Z", 1'b1);
    send_word(8'hff, 1'b1);

    // random phases; a phase may end mid stream so the write must restart it
    for (int unsigned p = 0; p < PHASES; p++) begin
      dir = (p < 2) ? logic'(p[0]) : logic'($urandom_range(0, 1));
      set_direction(dir);
      tx_steady = (p == 1);
      rx_steady = (p == 3);
      if (p == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = $urandom_range(1, 9);
        for (int unsigned k = 0; k < len && sent < PHASE_WORDS; k++) begin
          last = (k == len - 1);
          r = $urandom_range(0, 99);
          if (dir == DIR_ENCODE) begin
            if (r < 5) d = 8'h00;
            else if (r < 10) d = 8'hff;
            else d = 8'($urandom_range(0, 255));
          end else begin
            if (r < 88) d = codec_tracker::to_char(6'($urandom_range(0, 63)));
            else d = 8'($urandom_range(0, 255));
          end
          // stray end marks break the stream shape now and then
          if ($urandom_range(0, 19) == 0) last = ~last;
          if (!tracker.drops_next()) sent++;
          send_word(d, last);
        end
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
